[rtl/ttiab_pkg.sv]
// Shared types and constants for the text to integer converter.
`timescale 1ns / 1ps

package ttiab_pkg;

  // Field and register widths.
  localparam int BYTE_W      = 8;
  localparam int DIGIT_W     = 4;
  localparam int BASE_W      = 5;
  localparam int VALUE_W     = 64;
  localparam int ALPHABET_W  = 128;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SIZE        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_CHARS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIGIT_CHARS_HIGH = 2'd2;

  // Character codes.
  localparam logic [BYTE_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_VT    = 8'h0B;
  localparam logic [BYTE_W-1:0] CHAR_FF    = 8'h0C;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;

  // One classified character as it travels from the front end to the back end.
  typedef struct packed {
    logic               space;
    logic               minus;
    logic               plus;
    logic               digit_ok;
    logic [DIGIT_W-1:0] digit;
    logic               last;
  } class_item_t;

  // Queue status seen by the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

[rtl/text_to_integer_any_base.sv]
// Top level of the streaming text to integer converter with a configurable alphabet.
`timescale 1ns / 1ps

// Converts a string, one character per item, into a signed 64-bit integer in a
// base of up to 16 digits whose characters come from the configuration registers.
// One character is accepted every clock cycle while in_stall is low; the result of
// the last character is registered in the back end behind the queue. The front end
// classifies each character in the cycle it arrives, a two-entry queue holds them,
// and the back end does one multiply-add per character, so a stalled result holds
// the input off only once that queue is full. The user must write configuration via
// cfg_we, cfg_index and cfg_data only while no item is in flight; the block does not
// enforce it. Index 0 is the base size, 1 and 2 the low and high alphabet words.
module text_to_integer_any_base #(
  parameter int MAX_DIGITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [ttiab_pkg::BYTE_W-1:0]          in_text_byte,
  input  logic                                  in_last_byte,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [ttiab_pkg::VALUE_W-1:0]  out_parsed_value,
  input  logic                                  cfg_we,
  input  logic [ttiab_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ttiab_pkg::VALUE_W-1:0]         cfg_data
);
  import ttiab_pkg::*;

  logic [BASE_W-1:0]  base_size_r;
  logic [VALUE_W-1:0] digit_chars_low_r;
  logic [VALUE_W-1:0] digit_chars_high_r;
  class_item_t        front_item;
  class_item_t        head_item;
  queue_stat_t        q_stat;
  logic               q_take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_size_r        <= '0;
      digit_chars_low_r  <= '0;
      digit_chars_high_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BASE_SIZE:        base_size_r        <= cfg_data[BASE_W-1:0];
        CFG_DIGIT_CHARS_LOW:  digit_chars_low_r  <= cfg_data;
        CFG_DIGIT_CHARS_HIGH: digit_chars_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  ttiab_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .text_byte   (in_text_byte),
    .last_byte   (in_last_byte),
    .base_size   (base_size_r),
    .digit_chars ({digit_chars_high_r, digit_chars_low_r}),
    .item        (front_item)
  );

  ttiab_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_item (front_item),
    .pop       (q_take),
    .head_item (head_item),
    .stat      (q_stat)
  );

  assign in_stall = q_stat.full;

  ttiab_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .base_size        (base_size_r),
    .item             (head_item),
    .item_valid       (!q_stat.empty),
    .item_take        (q_take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_parsed_value (out_parsed_value)
  );

  // The queue is never reported full and empty at once.
  assert property (@(posedge clk) disable iff (!rst_n) !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // A new result only follows a last item taken by the back end.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(q_take && head_item.last))
    else $error("result raised without a last item");

  // A zero base always yields a zero result.
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_take && head_item.last && (base_size_r == '0)) |=> (out_parsed_value == '0))
    else $error("nonzero result with zero base");

  // The back end never takes an item from an empty queue.
  assert property (@(posedge clk) disable iff (!rst_n) q_take |-> !q_stat.empty)
    else $error("item taken from empty queue");

endmodule

[rtl/ttiab_front.sv]
// Front end: classifies each incoming character against whitespace, signs and the alphabet.
`timescale 1ns / 1ps

module ttiab_front #(
  parameter int MAX_DIGITS = 16
) (
  input  logic [ttiab_pkg::BYTE_W-1:0]     text_byte,
  input  logic                             last_byte,
  input  logic [ttiab_pkg::BASE_W-1:0]     base_size,
  input  logic [ttiab_pkg::ALPHABET_W-1:0] digit_chars,
  output ttiab_pkg::class_item_t           item
);
  import ttiab_pkg::*;

  logic               is_zero;
  logic               found;
  logic [DIGIT_W-1:0] digit;

  assign is_zero = (text_byte == CHAR_NUL);

  // Alphabet search; the loop runs downward so the lowest matching index wins.
  always_comb begin
    found = 1'b0;
    digit = '0;
    for (int k = MAX_DIGITS - 1; k >= 0; k--) begin
      if ((k < int'(base_size)) && (digit_chars[k*BYTE_W +: BYTE_W] == text_byte)) begin
        found = 1'b1;
        digit = DIGIT_W'(k);
      end
    end
  end

  // Pack the classification. A zero byte never counts as a digit.
  always_comb begin
    item.space    = (text_byte == CHAR_SPACE) || (text_byte == CHAR_TAB) ||
                    (text_byte == CHAR_LF) || (text_byte == CHAR_VT) ||
                    (text_byte == CHAR_FF) || (text_byte == CHAR_CR);
    item.minus    = (text_byte == CHAR_MINUS);
    item.plus     = (text_byte == CHAR_PLUS);
    item.digit_ok = found && !is_zero;
    item.digit    = digit;
    item.last     = last_byte;
  end

endmodule

[rtl/ttiab_queue.sv]
// Short queue of classified characters between the front end and the back end.
`timescale 1ns / 1ps

module ttiab_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  ttiab_pkg::class_item_t push_item,
  input  logic                   pop,
  output ttiab_pkg::class_item_t head_item,
  output ttiab_pkg::queue_stat_t stat
);
  import ttiab_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  class_item_t        slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  assign stat.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_item  = slot_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage slots carry no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[rtl/ttiab_back.sv]
// Back end: parse state, multiply-add accumulator and the result register.
`timescale 1ns / 1ps

module ttiab_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ttiab_pkg::BASE_W-1:0]  base_size,
  input  ttiab_pkg::class_item_t        item,
  input  logic                          item_valid,
  output logic                          item_take,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [ttiab_pkg::VALUE_W-1:0] out_parsed_value
);
  import ttiab_pkg::*;

  typedef enum logic [3:0] {
    PH_SPACE = 4'b0001,
    PH_SIGN  = 4'b0010,
    PH_DIGIT = 4'b0100,
    PH_DONE  = 4'b1000
  } phase_t;

  phase_t               phase_r, phase_nxt;
  logic                 parity_r, parity_nxt;
  logic [VALUE_W-1:0]   acc_r, acc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]   result_r, result_nxt;
  logic [VALUE_W-1:0]   product;

  // Accumulator times the base as one shifted add per set bit of the base.
  function automatic logic [VALUE_W-1:0] mul_small(input logic [VALUE_W-1:0] a,
                                                   input logic [BASE_W-1:0] m);
    logic [VALUE_W-1:0] s;
    s = '0;
    for (int i = 0; i < BASE_W; i++) begin
      if (m[i]) begin
        s = s + (a << i);
      end
    end
    return s;
  endfunction

  assign product = mul_small(acc_r, base_size);

  // A last item needs the result register free; other items always go through.
  assign item_take = item_valid && !(item.last && out_valid_r && out_stall);

  // Parse step for the item at the head of the queue.
  always_comb begin
    phase_t             ph;
    logic               par;
    logic [VALUE_W-1:0] acc;
    ph  = phase_r;
    par = parity_r;
    acc = acc_r;
    if ((ph == PH_SPACE) && !item.space) begin
      ph = PH_SIGN;
    end
    if (ph == PH_SIGN) begin
      if (item.minus) begin
        par = ~par;
      end else if (!item.plus) begin
        ph = PH_DIGIT;
      end
    end
    if (ph == PH_DIGIT) begin
      if (item.digit_ok) begin
        acc = product + VALUE_W'(item.digit);
      end else begin
        ph = PH_DONE;
      end
    end

    phase_nxt     = phase_r;
    parity_nxt    = parity_r;
    acc_nxt       = acc_r;
    result_nxt    = result_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (item_take) begin
      if (item.last) begin
        if (base_size == '0) begin
          result_nxt = '0;
        end else if (par) begin
          result_nxt = VALUE_W'(0) - acc;
        end else begin
          result_nxt = acc;
        end
        out_valid_nxt = 1'b1;
        phase_nxt     = PH_SPACE;
        parity_nxt    = 1'b0;
        acc_nxt       = '0;
      end else begin
        phase_nxt  = ph;
        parity_nxt = par;
        acc_nxt    = acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SPACE;
      parity_r    <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      parity_r    <= parity_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // The result payload needs no reset.
  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_parsed_value = $signed(result_r);

endmodule
